/* src/ioc_pkg.sv */
// ----------------------------------------------------------------------------
// ioc_pkg
// Shared codes, limits and controller/datapath signal groups of the request
// coalescer.
// ----------------------------------------------------------------------------
package ioc_pkg;

  typedef enum logic [1:0] {
    OP_SUBMIT   = 2'd0,
    OP_END      = 2'd1,
    OP_COMPLETE = 2'd2,
    OP_CANCEL   = 2'd3
  } op_t;

  localparam logic [1:0] KIND_REQ      = 2'd0;
  localparam logic [1:0] KIND_DONE     = 2'd1;
  localparam logic [1:0] KIND_UNWOUND  = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_SHORT    = 2'd1;
  localparam logic [1:0] STAT_ERROR    = 2'd2;

  localparam logic [5:0]  GROUP_LIMIT  = 6'd32;
  localparam logic [30:0] MAX_TOTAL    = 31'h3FFF_FFFF;
  localparam logic [31:0] SHORT_CODE   = 32'hFFFF_FFFB;

  localparam int IN_DATA_W  = 200;
  localparam int OUT_DATA_W = 208;

  // controller -> datapath
  typedef struct packed {
    logic emit_head;     // send the pending head out
    logic load_head;     // start a new head from the held request
    logic emit_single;   // send one pass-through completion or cancel
    logic take_entry;    // pop a pool entry and fill it
    logic link_entry;    // chain the new entry behind the tail
    logic walk_init;     // start the summing pass at the group head
    logic walk_sum;      // add one member, step to the next
    logic walk_restart;  // settle status, rewind to the group head
    logic walk_emit;     // send one member, free its entry, step on
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  op;
    logic head_valid;
    logic head_is_group;
    logic merge_ok;
    logic group_known;
    logic out_free;
    logic walk_more;
    logic emit_last;
  } stat_t;

endpackage

/* src/ioc_ram.sv */
// ----------------------------------------------------------------------------
// ioc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ioc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/ioc_ctrl.sv */
// ----------------------------------------------------------------------------
// ioc_ctrl
// Sequencer: decodes each request and steps merges and group walks.
// ----------------------------------------------------------------------------
module ioc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  ioc_pkg::stat_t stat,
  output ioc_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_POP_RD, ST_POP_DAT, ST_LINK,
    ST_W1_RD, ST_W1_DAT, ST_CHECK, ST_W2_RD, ST_W2_DAT
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (stat.op)
          ioc_pkg::OP_SUBMIT: begin
            if (stat.head_valid && stat.merge_ok) begin
              state_nxt = ST_POP_RD;
            end else if (!stat.head_valid) begin
              cmd.load_head = 1'b1;
              state_nxt     = ST_IDLE;
            end else if (stat.out_free) begin
              cmd.emit_head = 1'b1;
              cmd.load_head = 1'b1;
              state_nxt     = ST_IDLE;
            end
          end
          ioc_pkg::OP_END: begin
            if (!stat.head_valid) begin
              state_nxt = ST_IDLE;
            end else if (stat.out_free) begin
              cmd.emit_head = 1'b1;
              state_nxt     = ST_IDLE;
            end
          end
          default: begin
            if (stat.group_known) begin
              cmd.walk_init = 1'b1;
              state_nxt     = ST_W1_RD;
            end else if (stat.out_free) begin
              cmd.emit_single = 1'b1;
              state_nxt       = ST_IDLE;
            end
          end
        endcase
      end
      ST_POP_RD:  state_nxt = ST_POP_DAT;
      ST_POP_DAT: begin
        cmd.take_entry = 1'b1;
        state_nxt = stat.head_is_group ? ST_LINK : ST_POP_RD;
      end
      ST_LINK: begin
        cmd.link_entry = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_W1_RD:  state_nxt = ST_W1_DAT;
      ST_W1_DAT: begin
        cmd.walk_sum = 1'b1;
        state_nxt = stat.walk_more ? ST_W1_RD : ST_CHECK;
      end
      ST_CHECK: begin
        cmd.walk_restart = 1'b1;
        state_nxt        = ST_W2_RD;
      end
      ST_W2_RD:  state_nxt = ST_W2_DAT;
      ST_W2_DAT: begin
        if (stat.out_free) begin
          cmd.walk_emit = 1'b1;
          state_nxt = stat.emit_last ? ST_IDLE : ST_W2_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* src/ioc_datapath.sv */
// ----------------------------------------------------------------------------
// ioc_datapath
// Held request, pending head, entry pool, group walk and result register.
// ----------------------------------------------------------------------------
module ioc_datapath #(
  parameter int POOL_ENTRIES = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_fire,
  input  logic [ioc_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [1:0]                       in_tuser,
  input  ioc_pkg::cmd_t                    cmd,
  output ioc_pkg::stat_t                   stat,
  input  logic                             out_tready,
  output logic                             out_tvalid,
  output logic [ioc_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [1:0]                       out_tuser,
  output logic                             out_tlast
);

  localparam int IW = $clog2(POOL_ENTRIES);
  localparam int NW = $clog2(POOL_ENTRIES + 1);
  localparam logic [NW-1:0] NO_NEXT = NW'(POOL_ENTRIES);

  // held request
  logic [ioc_pkg::IN_DATA_W-1:0] in_data_r;
  ioc_pkg::op_t                  in_op_r;

  logic [15:0] i_handle;
  logic [2:0]  i_opcode;
  logic [47:0] i_offset, i_buffer;
  logic [23:0] i_len;
  logic [15:0] i_tag;
  logic        i_isgrp;
  logic [4:0]  i_slot;
  logic [31:0] i_cv;
  logic [IW-1:0] slot_idx;

  assign i_handle = in_data_r[15:0];
  assign i_opcode = in_data_r[18:16];
  assign i_offset = in_data_r[66:19];
  assign i_buffer = in_data_r[114:67];
  assign i_len    = in_data_r[138:115];
  assign i_tag    = in_data_r[154:139];
  assign i_isgrp  = in_data_r[155];
  assign i_slot   = in_data_r[160:156];
  assign i_cv     = in_data_r[192:161];
  assign slot_idx = IW'(i_slot);

  // pending head
  logic        hv_r;
  logic [15:0] hd_handle_r;
  logic [2:0]  hd_opcode_r;
  logic [47:0] hd_off_r, hd_buf_r;
  logic [29:0] hd_len_r;
  logic [15:0] hd_tag_r;
  logic        gi_grp_r;
  logic [IW-1:0] gi_slot_r, gi_tail_r, e2_r;
  logic [5:0]  gi_cnt_r;

  // pool
  logic [NW-1:0]           fc_r;
  logic [POOL_ENTRIES-1:0] touched_r, live_r;
  logic                    touched_q_r;
  logic [IW-1:0]           fs_idx_q_r, fs_raddr, fs_rdata, fs_entry;
  logic                    fs_we;

  logic          md_we, mn_we;
  logic [IW-1:0] md_waddr, mn_waddr;
  logic [39:0]   md_wdata, md_rdata;
  logic [NW-1:0] mn_wdata, mn_rdata;

  // walk
  logic [IW-1:0] ptr_r;
  logic [5:0]    n_r, i_r;
  logic [29:0]   total_r;
  logic [1:0]    st_r;
  logic          err_r;
  logic [31:0]   code_r;
  logic [15:0]   m_tag;
  logic [23:0]   m_len;

  // result register
  logic                           out_valid_r;
  logic [ioc_pkg::OUT_DATA_W-1:0] o_data_r, o_data_nxt;
  logic [1:0]                     o_kind_r, o_kind_nxt;
  logic                           o_last_r, o_last_nxt;
  logic                           out_load, out_free;

  logic [47:0] off_end, buf_end;
  logic [30:0] sum31;
  logic        err_now;
  logic [1:0]  walk_kind;

  assign fs_raddr = IW'(fc_r - NW'(1));
  assign fs_entry = touched_q_r ? fs_rdata : fs_idx_q_r;
  assign fs_we    = cmd.walk_emit && (fc_r < NO_NEXT);

  ioc_ram #(.WIDTH(IW), .DEPTH(POOL_ENTRIES)) u_free_stack (
    .clk(clk), .we(fs_we), .waddr(IW'(fc_r)), .wdata(ptr_r),
    .raddr(fs_raddr), .rdata(fs_rdata)
  );

  assign md_we    = cmd.take_entry;
  assign md_waddr = fs_entry;
  assign md_wdata = gi_grp_r ? {i_tag, i_len} : {hd_tag_r, hd_len_r[23:0]};
  assign mn_we    = cmd.take_entry || cmd.link_entry;
  assign mn_waddr = cmd.link_entry ? gi_tail_r : fs_entry;
  assign mn_wdata = cmd.link_entry ? NW'(e2_r) : NO_NEXT;

  ioc_ram #(.WIDTH(40), .DEPTH(POOL_ENTRIES)) u_member_data (
    .clk(clk), .we(md_we), .waddr(md_waddr), .wdata(md_wdata),
    .raddr(ptr_r), .rdata(md_rdata)
  );

  ioc_ram #(.WIDTH(NW), .DEPTH(POOL_ENTRIES)) u_member_next (
    .clk(clk), .we(mn_we), .waddr(mn_waddr), .wdata(mn_wdata),
    .raddr(ptr_r), .rdata(mn_rdata)
  );

  assign m_tag = md_rdata[39:24];
  assign m_len = md_rdata[23:0];

  // merge checks
  assign off_end = hd_off_r + 48'(hd_len_r);
  assign buf_end = hd_buf_r + 48'(hd_len_r);
  assign sum31   = {1'b0, hd_len_r} + 31'(i_len);

  assign out_free = !out_valid_r || out_tready;
  assign out_load = cmd.emit_head || cmd.emit_single || cmd.walk_emit;

  assign err_now = (in_op_r == ioc_pkg::OP_COMPLETE) && (i_cv != 32'(total_r));
  assign walk_kind = (in_op_r == ioc_pkg::OP_COMPLETE) ? ioc_pkg::KIND_DONE
                                                       : ioc_pkg::KIND_UNWOUND;

  always_comb begin
    stat               = '0;
    stat.op            = in_op_r;
    stat.head_valid    = hv_r;
    stat.head_is_group = gi_grp_r;
    stat.merge_ok      = (i_handle == hd_handle_r) && (i_opcode == hd_opcode_r)
                      && (off_end == i_offset) && (buf_end == i_buffer)
                      && (fc_r >= (gi_grp_r ? NW'(1) : NW'(2)))
                      && (sum31 <= ioc_pkg::MAX_TOTAL)
                      && (!gi_grp_r || (gi_cnt_r < ioc_pkg::GROUP_LIMIT));
    stat.group_known   = i_isgrp && (32'(i_slot) < 32'(POOL_ENTRIES)) && live_r[slot_idx];
    stat.out_free      = out_free;
    stat.walk_more     = ((n_r + 6'd1) < ioc_pkg::GROUP_LIMIT) && (mn_rdata < NO_NEXT);
    stat.emit_last     = (i_r == (n_r - 6'd1));
  end

  // result payload
  always_comb begin
    o_data_nxt = o_data_r;
    o_kind_nxt = o_kind_r;
    o_last_nxt = o_last_r;
    priority if (cmd.emit_head) begin
      o_kind_nxt = ioc_pkg::KIND_REQ;
      o_last_nxt = 1'b1;
      o_data_nxt = {7'd0, 32'd0, ioc_pkg::STAT_OK,
                    gi_grp_r ? 5'(gi_slot_r) : 5'd0, gi_grp_r,
                    hd_tag_r, hd_len_r, hd_buf_r, hd_off_r, hd_opcode_r, hd_handle_r};
    end else if (cmd.emit_single) begin
      o_kind_nxt = walk_kind;
      o_last_nxt = 1'b1;
      if (in_op_r == ioc_pkg::OP_COMPLETE) begin
        o_data_nxt = {7'd0, i_cv, ioc_pkg::STAT_OK, 5'd0, 1'b0,
                      i_tag, 30'd0, 48'd0, 48'd0, 3'd0, 16'd0};
      end else begin
        o_data_nxt = {7'd0, 32'(i_len), ioc_pkg::STAT_OK, 5'd0, 1'b0,
                      i_tag, 30'(i_len), 48'd0, 48'd0, 3'd0, 16'd0};
      end
    end else if (cmd.walk_emit) begin
      o_kind_nxt = walk_kind;
      o_last_nxt = stat.emit_last;
      o_data_nxt = {7'd0, err_r ? code_r : 32'(m_len), st_r, i_slot, 1'b1,
                    m_tag, 30'(m_len), 48'd0, 48'd0, 3'd0, 16'd0};
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r        <= 1'b0;
      gi_grp_r    <= 1'b0;
      fc_r        <= NO_NEXT;
      touched_r   <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.emit_head) begin
        hv_r     <= 1'b0;
        gi_grp_r <= 1'b0;
        if (gi_grp_r) live_r[gi_slot_r] <= 1'b1;
      end
      if (cmd.load_head) begin
        hv_r     <= 1'b1;
        gi_grp_r <= 1'b0;
      end
      if (cmd.take_entry) begin
        fc_r             <= fc_r - NW'(1);
        live_r[fs_entry] <= 1'b0;
        gi_grp_r         <= 1'b1;
      end
      if (cmd.walk_restart) live_r[slot_idx] <= 1'b0;
      if (fs_we) begin
        fc_r               <= fc_r + NW'(1);
        touched_r[IW'(fc_r)] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    touched_q_r <= touched_r[fs_raddr];
    fs_idx_q_r  <= fs_raddr;
    o_data_r    <= o_data_nxt;
    o_kind_r    <= o_kind_nxt;
    o_last_r    <= o_last_nxt;
    if (in_fire) begin
      in_data_r <= in_tdata;
      in_op_r   <= ioc_pkg::op_t'(in_tuser);
    end
    if (cmd.load_head) begin
      hd_handle_r <= i_handle;
      hd_opcode_r <= i_opcode;
      hd_off_r    <= i_offset;
      hd_buf_r    <= i_buffer;
      hd_len_r    <= 30'(i_len);
      hd_tag_r    <= i_tag;
    end
    if (cmd.take_entry) begin
      if (!gi_grp_r) begin
        gi_slot_r <= fs_entry;
        gi_tail_r <= fs_entry;
        gi_cnt_r  <= 6'd1;
      end else begin
        e2_r <= fs_entry;
      end
    end
    if (cmd.link_entry) begin
      gi_tail_r <= e2_r;
      gi_cnt_r  <= gi_cnt_r + 6'd1;
      hd_len_r  <= sum31[29:0];
    end
    if (cmd.walk_init) begin
      ptr_r   <= slot_idx;
      n_r     <= 6'd0;
      total_r <= 30'd0;
    end
    if (cmd.walk_sum) begin
      n_r     <= n_r + 6'd1;
      total_r <= total_r + 30'(m_len);
      ptr_r   <= IW'(mn_rdata);
    end
    if (cmd.walk_restart) begin
      ptr_r  <= slot_idx;
      i_r    <= 6'd0;
      err_r  <= err_now;
      st_r   <= !err_now ? ioc_pkg::STAT_OK
              : (i_cv[31] ? ioc_pkg::STAT_ERROR : ioc_pkg::STAT_SHORT);
      code_r <= i_cv[31] ? i_cv : ioc_pkg::SHORT_CODE;
    end
    if (cmd.walk_emit) begin
      i_r   <= i_r + 6'd1;
      ptr_r <= IW'(mn_rdata);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = o_data_r;
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_last_r;

endmodule

/* src/io_request_coalescer_unit.sv */
// Flow: a request is taken when idle and decoded in the cycle after; a plain submit or
// end of batch ends at decode, a merge pops one pool entry (two if the head is not yet a
// group, free stack reads are registered) and links it. A group completion or cancel walks
// the member list twice on the shared member RAM read port, one result per member.
// Reset (rst_n low, synchronous): head dropped, pool count full, live and valid bits
// cleared; no clearing pass, the block takes requests straight after reset.
// ----------------------------------------------------------------------------
// io_request_coalescer_unit
// Merges contiguous disk requests into groups and splits group completions.
// ----------------------------------------------------------------------------
module io_request_coalescer_unit #(
  parameter int POOL_ENTRIES = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  // handle[15:0] opcode[18:16] offset[66:19] buffer_addr[114:67] length[138:115]
  // tag[154:139] is_group[155] group_slot[160:156] completion_value[192:161]
  input  logic [199:0] in_tdata,
  input  logic [1:0]   in_tuser,   // op[1:0]
  input  logic         in_tvalid,
  output logic         in_tready,
  // out_handle[15:0] out_opcode[18:16] out_offset[66:19] out_buffer[114:67]
  // out_length[144:115] out_tag[160:145] out_is_group[161] out_group_slot[166:162]
  // status[168:167] value[200:169]
  output logic [207:0] out_tdata,
  output logic [1:0]   out_tuser,  // kind[1:0]
  output logic         out_tlast,  // last
  output logic         out_tvalid,
  input  logic         out_tready
);

  ioc_pkg::cmd_t  cmd;
  ioc_pkg::stat_t stat;
  logic           in_fire;

  // hold each request until its decode completes
  assign in_fire = in_tvalid && in_tready;

  // sequencer: one request at a time
  ioc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .stat(stat), .cmd(cmd)
  );

  // head, pool, group walk and result register
  ioc_datapath #(.POOL_ENTRIES(POOL_ENTRIES)) u_datapath (
    .clk(clk), .rst_n(rst_n),
    .in_fire(in_fire), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .cmd(cmd), .stat(stat),
    .out_tready(out_tready), .out_tvalid(out_tvalid),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

`ifndef SYNTH
  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.emit_head, cmd.emit_single, cmd.walk_emit}))
    else $error("two result loads in one cycle");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_head || cmd.emit_single || cmd.walk_emit) |-> stat.out_free)
    else $error("result register overwritten");

  a_group_head: assert property (@(posedge clk) disable iff (!rst_n)
    stat.head_is_group |-> stat.head_valid)
    else $error("group without pending head");
`endif

endmodule

/* dv/io_request_coalescer_unit_tb.sv */
// ----------------------------------------------------------------------------
// io_request_coalescer_unit_tb
// Drives submit, end of batch, completion and cancel requests into the
// coalescer and compares every result with a cycle-free predictor of merge,
// emit and group walk behavior.
// ----------------------------------------------------------------------------
module io_request_coalescer_unit_tb;

  localparam int              POOL      = 32;
  localparam logic [5:0]      NO_NEXT   = 6'd32;
  localparam logic [47:0]     MASK48    = 48'hFFFF_FFFF_FFFF;
  localparam int              N_RANDOM  = 320;

  typedef struct {
    logic [15:0] handle;
    logic [2:0]  opcode;
    logic [47:0] offset;
    logic [47:0] buffer;
    logic [23:0] length;
    logic [15:0] tag;
    logic        is_group;
    logic [4:0]  slot;
    logic [31:0] cvalue;
  } request_t;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] handle;
    logic [2:0]  opcode;
    logic [47:0] offset;
    logic [47:0] buffer;
    logic [29:0] length;
    logic [15:0] tag;
    logic        is_group;
    logic [4:0]  slot;
    logic [1:0]  status;
    logic [31:0] value;
    logic        last;
  } result_t;

  logic         clk;
  logic         rst_n;
  logic [199:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         in_tvalid;
  logic         in_tready;
  logic [207:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;
  logic         out_tvalid;
  logic         out_tready;

  io_request_coalescer_unit #(.POOL_ENTRIES(POOL)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  // Predictor state: pool lists, free stack and the pending head.
  logic [15:0] pool_tag   [POOL];
  logic [23:0] pool_len   [POOL];
  logic [5:0]  pool_next  [POOL];
  logic        pool_live  [POOL];
  logic [4:0]  free_stack [POOL];
  int          free_cnt;
  logic        head_valid;
  request_t    head_req;
  logic [30:0] head_total;
  logic        head_grouped;
  logic [4:0]  head_slot;
  logic [4:0]  head_tail;
  int          head_members;

  result_t     pending_results[$];
  int          error_cnt;
  int          result_cnt;
  int          merge_cnt;
  int          walk_cnt;
  logic        no_idle;
  logic        hold_req;
  int          hold_cnt;
  int          stall_cnt;

  // Clock: period 4.
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    error_cnt++;
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
  endtask

  // Reset the predictor to the block's reset state.
  task automatic clear_model();
    for (int i = 0; i < POOL; i++) begin
      pool_live[i]  = 1'b0;
      pool_next[i]  = NO_NEXT;
      free_stack[i] = i[4:0];
    end
    free_cnt     = POOL;
    head_valid   = 1'b0;
    head_grouped = 1'b0;
    head_members = 0;
  endtask

  function automatic logic [4:0] pool_take();
    free_cnt--;
    return free_stack[free_cnt];
  endfunction

  function automatic logic joins_head(request_t q);
    int need;
    int members;
    need    = head_grouped ? 1 : 2;
    members = head_grouped ? head_members : 1;
    if (q.handle != head_req.handle || q.opcode != head_req.opcode) return 1'b0;
    if (((head_req.offset + 48'(head_total)) & MASK48) != q.offset) return 1'b0;
    if (((head_req.buffer + 48'(head_total)) & MASK48) != q.buffer) return 1'b0;
    if (free_cnt < need) return 1'b0;
    if (head_total + 31'(q.length) > ioc_pkg::MAX_TOTAL) return 1'b0;
    if (members + 1 > ioc_pkg::GROUP_LIMIT) return 1'b0;
    return 1'b1;
  endfunction

  task automatic emit_head();
    result_t r;
    r = '{default: '0};
    r.kind   = ioc_pkg::KIND_REQ;
    r.handle = head_req.handle;
    r.opcode = head_req.opcode;
    r.offset = head_req.offset;
    r.buffer = head_req.buffer;
    r.length = head_total[29:0];
    r.tag    = head_req.tag;
    r.last   = 1'b1;
    if (head_grouped) begin
      r.is_group = 1'b1;
      r.slot     = head_slot;
      pool_live[head_slot] = 1'b1;
    end
    pending_results.push_back(r);
    head_valid   = 1'b0;
    head_grouped = 1'b0;
    head_members = 0;
  endtask

  function automatic logic [31:0] group_total(input logic [4:0] slot);
    logic [5:0]  s;
    logic [31:0] sum;
    int          n;
    s = {1'b0, slot};
    sum = '0;
    n = 0;
    while (n < 32 && s < NO_NEXT) begin
      sum += 32'(pool_len[s[4:0]]);
      s = pool_next[s[4:0]];
      n++;
    end
    return sum;
  endfunction

  // Work out the results of one accepted request and queue them.
  task automatic predict_results(input ioc_pkg::op_t op, input request_t q);
    result_t     r;
    logic [4:0]  members[$];
    logic [5:0]  s;
    logic [4:0]  e;
    logic [31:0] total;
    logic [31:0] code;
    logic [1:0]  st;
    logic        err;
    if (op == ioc_pkg::OP_SUBMIT) begin
      if (head_valid && joins_head(q)) begin
        if (!head_grouped) begin
          e = pool_take();
          pool_tag[e] = head_req.tag;
          pool_len[e] = head_req.length;
          pool_next[e] = NO_NEXT;
          pool_live[e] = 1'b0;
          head_grouped = 1'b1;
          head_slot = e;
          head_tail = e;
          head_members = 1;
        end
        e = pool_take();
        pool_tag[e]  = q.tag;
        pool_len[e]  = q.length;
        pool_next[e] = NO_NEXT;
        pool_live[e] = 1'b0;
        pool_next[head_tail] = {1'b0, e};
        head_tail = e;
        head_members++;
        head_total += 31'(q.length);
        merge_cnt++;
      end else begin
        if (head_valid) emit_head();
        head_req     = q;
        head_total   = 31'(q.length);
        head_grouped = 1'b0;
        head_members = 0;
        head_valid   = 1'b1;
      end
    end else if (op == ioc_pkg::OP_END) begin
      if (head_valid) emit_head();
    end else if (!q.is_group || !pool_live[q.slot]) begin
      // Pass a plain or unknown-group item straight through.
      r = '{default: '0};
      r.kind = (op == ioc_pkg::OP_COMPLETE) ? ioc_pkg::KIND_DONE : ioc_pkg::KIND_UNWOUND;
      r.tag  = q.tag;
      r.last = 1'b1;
      if (op == ioc_pkg::OP_COMPLETE) r.value = q.cvalue;
      else begin
        r.length = 30'(q.length);
        r.value  = 32'(q.length);
      end
      pending_results.push_back(r);
    end else begin
      s = {1'b0, q.slot};
      total = '0;
      while (members.size() < 32 && s < NO_NEXT) begin
        members.push_back(s[4:0]);
        total += 32'(pool_len[s[4:0]]);
        s = pool_next[s[4:0]];
      end
      err  = 1'b0;
      st   = ioc_pkg::STAT_OK;
      code = '0;
      if (op == ioc_pkg::OP_COMPLETE && q.cvalue != total) begin
        err = 1'b1;
        if (q.cvalue[31]) begin
          st = ioc_pkg::STAT_ERROR;
          code = q.cvalue;
        end else begin
          st = ioc_pkg::STAT_SHORT;
          code = ioc_pkg::SHORT_CODE;
        end
      end
      pool_live[q.slot] = 1'b0;
      walk_cnt++;
      foreach (members[i]) begin
        e = members[i];
        r = '{default: '0};
        r.kind     = (op == ioc_pkg::OP_COMPLETE) ? ioc_pkg::KIND_DONE
                                                  : ioc_pkg::KIND_UNWOUND;
        r.length   = 30'(pool_len[e]);
        r.tag      = pool_tag[e];
        r.is_group = 1'b1;
        r.slot     = q.slot;
        r.status   = st;
        r.value    = err ? code : 32'(pool_len[e]);
        r.last     = (i == members.size() - 1);
        pending_results.push_back(r);
        pool_next[e] = NO_NEXT;
        if (free_cnt < POOL) begin
          free_stack[free_cnt] = e;
          free_cnt++;
        end
      end
    end
  endtask

  function automatic int gap_cycles();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one request, wait for the handshake, then predict its results.
  task automatic send_request(input ioc_pkg::op_t op, input request_t q);
    int gap;
    gap = gap_cycles();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tuser  = op;
    in_tdata  = {7'd0, q.cvalue, q.slot, q.is_group, q.tag, q.length, q.buffer,
                 q.offset, q.opcode, q.handle};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_results(op, q);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  function automatic logic [47:0] rand48();
    return {$urandom(), $urandom()} & MASK48;
  endfunction

  function automatic request_t rand_request();
    request_t q;
    q.handle   = $urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 3));
    q.opcode   = 3'($urandom_range(0, 7));
    q.offset   = rand48();
    q.buffer   = rand48();
    case ($urandom_range(0, 9))
      0:       q.length = 24'($urandom());
      1:       q.length = 24'hFF_FFFF;
      2:       q.length = '0;
      default: q.length = 24'($urandom_range(1, 4096));
    endcase
    q.tag      = 16'($urandom());
    q.is_group = 1'($urandom());
    q.slot     = 5'($urandom());
    q.cvalue   = $urandom();
    return q;
  endfunction

  // A submit that continues the pending head.
  function automatic request_t follow_request();
    request_t q;
    q = rand_request();
    q.handle = head_req.handle;
    q.opcode = head_req.opcode;
    q.offset = (head_req.offset + 48'(head_total)) & MASK48;
    q.buffer = (head_req.buffer + 48'(head_total)) & MASK48;
    if (q.length > 24'd65536 && $urandom_range(0, 3) != 0) q.length = 24'($urandom_range(0, 999));
    return q;
  endfunction

  // Complete or cancel a live group with a full, short or error value.
  task automatic finish_group(input logic [4:0] slot, input ioc_pkg::op_t op, input int how);
    request_t    q;
    logic [31:0] total;
    q = rand_request();
    q.is_group = 1'b1;
    q.slot     = slot;
    total      = group_total(slot);
    case (how)
      0:       q.cvalue = total;
      1:       q.cvalue = (total == 0) ? 32'd1 : 32'($urandom_range(0, total - 1));
      default: q.cvalue = {1'b1, 31'($urandom())};
    endcase
    send_request(op, q);
  endtask

  function automatic int pick_live();
    int live[$];
    for (int i = 0; i < POOL; i++) if (pool_live[i]) live.push_back(i);
    if (live.size() == 0) return -1;
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  // Field extremes, both plain paths, wrap of offsets, error and unknown slots.
  task automatic test_extremes();
    request_t q;
    q = '{16'hFFFF, 3'd7, MASK48, MASK48, 24'hFF_FFFF, 16'hFFFF, 1'b1, 5'd31,
          32'h7FFF_FFFF};
    send_request(ioc_pkg::OP_SUBMIT, q);
    send_request(ioc_pkg::OP_SUBMIT, follow_request());  // merges across the 2^48 wrap
    send_request(ioc_pkg::OP_END, q);
    finish_group(head_slot, ioc_pkg::OP_COMPLETE, 2);
    q = '{default: '0};
    send_request(ioc_pkg::OP_SUBMIT, q);
    send_request(ioc_pkg::OP_END, q);
    send_request(ioc_pkg::OP_END, q);                     // no head: no result
    q.cvalue = 32'h8000_0000;
    send_request(ioc_pkg::OP_COMPLETE, q);                // plain completion
    q = '{16'hFFFF, 3'd7, MASK48, MASK48, 24'hFF_FFFF, 16'hFFFF, 1'b0, 5'd31,
          32'h7FFF_FFFF};
    send_request(ioc_pkg::OP_COMPLETE, q);
    send_request(ioc_pkg::OP_CANCEL, q);                  // plain cancel
    q.is_group = 1'b1;
    send_request(ioc_pkg::OP_CANCEL, q);                  // unknown group slot
    send_request(ioc_pkg::OP_COMPLETE, q);
    q = rand_request();
    send_request(ioc_pkg::OP_SUBMIT, q);
    send_request(ioc_pkg::OP_SUBMIT, follow_request());
    send_request(ioc_pkg::OP_SUBMIT, follow_request());
    q = rand_request();
    q.handle = ~head_req.handle;
    send_request(ioc_pkg::OP_SUBMIT, q);                  // breaks the run, emits group
    send_request(ioc_pkg::OP_END, q);
    finish_group(5'(pick_live()), ioc_pkg::OP_CANCEL, 0);
    drop_valid();
  endtask

  // Fill one group to the member limit, then try to merge with no pool left.
  task automatic test_limits();
    request_t q;
    logic [4:0] big;
    q = rand_request();
    q.length = 24'd512;
    send_request(ioc_pkg::OP_SUBMIT, q);
    repeat (32) send_request(ioc_pkg::OP_SUBMIT, follow_request());  // last one is refused
    big = head_slot;
    send_request(ioc_pkg::OP_END, q);
    q = rand_request();
    send_request(ioc_pkg::OP_SUBMIT, q);
    send_request(ioc_pkg::OP_SUBMIT, follow_request());  // empty pool: refused
    send_request(ioc_pkg::OP_END, q);
    finish_group(big, ioc_pkg::OP_COMPLETE, 1);
    drop_valid();
  endtask

  // Mostly contiguous runs with random content, plus completions and noise.
  task automatic test_random();
    request_t q;
    int       sent;
    int       slot;
    int       p;
    sent = 0;
    while (sent < N_RANDOM) begin
      if (sent % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (sent == 150) hold_req = 1'b1;
      p = $urandom_range(0, 99);
      slot = pick_live();
      if (p < 45 && head_valid) begin
        send_request(ioc_pkg::OP_SUBMIT, follow_request());
      end else if (p < 65) begin
        send_request(ioc_pkg::OP_SUBMIT, rand_request());
      end else if (p < 73) begin
        send_request(ioc_pkg::OP_END, rand_request());
      end else if (p < 90 && slot >= 0) begin
        finish_group(5'(slot), $urandom_range(0, 2) != 0 ? ioc_pkg::OP_COMPLETE
                                                         : ioc_pkg::OP_CANCEL,
                     $urandom_range(0, 2));
      end else begin
        q = rand_request();
        send_request($urandom_range(0, 1) ? ioc_pkg::OP_COMPLETE : ioc_pkg::OP_CANCEL, q);
      end
      sent++;
    end
    send_request(ioc_pkg::OP_END, rand_request());
    no_idle = 1'b0;
    drop_valid();
  endtask

  // Receiver: random stalls, occasional long ones, and one long hold-off.
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready = 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = 400;
      out_tready = 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      out_tready = 1'b0;
    end else if (no_idle) begin
      out_tready = 1'b1;
    end else if ($urandom_range(0, 199) == 0) begin
      stall_cnt = $urandom_range(10, 40);
      out_tready = 1'b0;
    end else begin
      out_tready = ($urandom_range(0, 99) < 75);
    end
  end

  // Check every accepted result against the oldest expectation.
  always @(posedge clk) begin
    result_t w;
    if (rst_n && out_tvalid && out_tready) begin
      result_cnt++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result kind", 64'(out_tuser), 64'd0);
      end else begin
        w = pending_results.pop_front();
        if (out_tuser != w.kind)              report_mismatch("kind", out_tuser, w.kind);
        if (out_tdata[15:0] != w.handle)      report_mismatch("handle", out_tdata[15:0], w.handle);
        if (out_tdata[18:16] != w.opcode)     report_mismatch("opcode", out_tdata[18:16], w.opcode);
        if (out_tdata[66:19] != w.offset)     report_mismatch("offset", out_tdata[66:19], w.offset);
        if (out_tdata[114:67] != w.buffer)    report_mismatch("buffer", out_tdata[114:67], w.buffer);
        if (out_tdata[144:115] != w.length)   report_mismatch("length", out_tdata[144:115], w.length);
        if (out_tdata[160:145] != w.tag)      report_mismatch("tag", out_tdata[160:145], w.tag);
        if (out_tdata[161] != w.is_group)     report_mismatch("is_group", out_tdata[161], w.is_group);
        if (out_tdata[166:162] != w.slot)     report_mismatch("group_slot", out_tdata[166:162], w.slot);
        if (out_tdata[168:167] != w.status)   report_mismatch("status", out_tdata[168:167], w.status);
        if (out_tdata[200:169] != w.value)    report_mismatch("value", out_tdata[200:169], w.value);
        if (out_tlast != w.last)              report_mismatch("last", out_tlast, w.last);
      end
    end
  end

  // Watchdog.
  initial begin
    #8000000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    error_cnt = 0;
    result_cnt = 0;
    merge_cnt = 0;
    walk_cnt = 0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    hold_cnt = 0;
    stall_cnt = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    out_tready = 1'b0;
    clear_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_extremes();
    test_limits();
    test_random();

    // Drain, then let any late extra result show up.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("covered %0d results, %0d merges, %0d group walks", result_cnt, merge_cnt,
             walk_cnt);
    $display("runs of contiguous submits, member and pool limits, and one long output hold");
    if (error_cnt == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
